### src/bdcc_pkg.sv
// bdcc_pkg: shared types and constants for the button debounce click counter
// no dependencies; imported by the top level and its checker

package bdcc_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned MsW       = 16;
    localparam int unsigned CountW    = 7;
    localparam int unsigned ClicksW   = 8;
    localparam int unsigned CfgIdxW   = 8;
    localparam int unsigned CfgDataW  = 16;
    localparam int unsigned STdataW   = 40;
    localparam int unsigned MTdataW   = 16;

    localparam logic [CountW-1:0] CountMax = '1;

    // register indexes of the configuration channel
    localparam logic [CfgIdxW-1:0] RegMultiClick = 8'd0;
    localparam logic [CfgIdxW-1:0] RegDebounceMs = 8'd1;
    localparam logic [CfgIdxW-1:0] RegGapMs      = 8'd2;
    localparam logic [CfgIdxW-1:0] RegLongMs     = 8'd3;

    // reset values of the timing registers
    localparam logic [MsW-1:0] DebounceMsRst = 16'd20;
    localparam logic [MsW-1:0] GapMsRst      = 16'd400;
    localparam logic [MsW-1:0] LongMsRst     = 16'd1000;

    // item kind carried in s_axis tuser
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_FETCH  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic           multi_click;
        logic [MsW-1:0] debounce_ms;
        logic [MsW-1:0] gap_ms;
        logic [MsW-1:0] long_ms;
    } cfg_t;

endpackage

### src/button_debounce_click_counter_unit.sv
// button_debounce_click_counter_unit: debounced button with click counting,
// multi-click and long-press publishing; single module
// depends on bdcc_pkg
//
// usage:
//   s_axis carries one item per transaction. tuser is the command (sample or
//   fetch). tdata[0] is the raw active-low pin level, tdata[32:1] the wrapping
//   millisecond time, the rest is zero. Fetch items ignore tdata.
//   m_axis returns exactly one result per input item, in order. tdata[0] is the
//   debounced pressed state, tdata[8:1] the signed fetched click value (zero
//   for samples).
//   cfg_* writes one of four registers (multi_click, debounce_ms, gap_ms,
//   long_ms) by index; unknown indexes are dropped. It is always ready; the
//   user must write it only while no item is in flight; the block does not enforce this.
// timing:
//   an accepted item passes one input register, then one pass of
//   subtract/compare logic into the result register that drives m_axis_tvalid.
//   throughput is one item per cycle while m_axis_tready is high; the
//   elapsed-time subtract and the three 32-bit compares set the critical path.
// reset and stall:
//   aresetn (synchronous, active low) empties both stages and restores the
//   register defaults and the button state. When m_axis_tready is low the
//   result holds, the input stage fills and then s_axis_tready drops.

module button_debounce_click_counter_unit
    import bdcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [STdataW-1:0]   s_axis_tdata,   // [0] pin_level, [32:1] now_ms, zero pad
    input  logic                 s_axis_tuser,   // [0] command

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [MTdataW-1:0]   m_axis_tdata,   // [0] pressed, [8:1] clicks, zero pad

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // input stage
    logic               in_valid_reg;
    cmd_t               in_cmd_reg;
    logic               in_pin_reg;
    logic [TimeW-1:0]   in_now_reg;

    // button state
    logic               last_raw_reg,    last_raw_next;
    logic               stable_reg,      stable_next;
    logic [TimeW-1:0]   stamp_reg,       stamp_next;
    logic [CountW-1:0]  count_reg,       count_next;
    logic [ClicksW-1:0] published_reg,   published_next;

    // result stage
    logic               out_valid_reg;
    logic               out_pressed_reg;
    logic [ClicksW-1:0] out_clicks_reg;
    logic [ClicksW-1:0] fetched;

    logic               advance;
    logic               raw;
    logic [TimeW-1:0]   elapsed;
    logic               deb_hit;
    logic               gap_hit;
    logic               long_hit;

    // the input stage moves on when the result stage is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.multi_click <= 1'b0;
            cfg_reg.debounce_ms <= DebounceMsRst;
            cfg_reg.gap_ms      <= GapMsRst;
            cfg_reg.long_ms     <= LongMsRst;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                RegMultiClick: cfg_reg.multi_click <= cfg_data[0];
                RegDebounceMs: cfg_reg.debounce_ms <= cfg_data[MsW-1:0];
                RegGapMs:      cfg_reg.gap_ms      <= cfg_data[MsW-1:0];
                RegLongMs:     cfg_reg.long_ms     <= cfg_data[MsW-1:0];
                default:       ;  // unknown index, write dropped
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_cmd_reg <= cmd_t'(s_axis_tuser);
            in_pin_reg <= s_axis_tdata[0];
            in_now_reg <= s_axis_tdata[TimeW:1];
        end
    end

    // one pass of the debounce and click rules
    always_comb begin
        last_raw_next  = last_raw_reg;
        stable_next    = stable_reg;
        stamp_next     = stamp_reg;
        count_next     = count_reg;
        published_next = published_reg;
        fetched        = '0;

        // pin is active low, raw 1 means pressed
        raw = ~in_pin_reg;

        if (raw != last_raw_reg) begin
            stamp_next = in_now_reg;
        end
        // modular difference, a backward timestamp gives a large value
        elapsed  = in_now_reg - stamp_next;
        deb_hit  = elapsed > {{(TimeW-MsW){1'b0}}, cfg_reg.debounce_ms};
        gap_hit  = elapsed > {{(TimeW-MsW){1'b0}}, cfg_reg.gap_ms};
        long_hit = elapsed > {{(TimeW-MsW){1'b0}}, cfg_reg.long_ms};

        case (in_cmd_reg)
            CMD_FETCH: begin
                fetched        = published_reg;
                published_next = '0;
                // sample state is left alone
                stamp_next     = stamp_reg;
            end
            CMD_SAMPLE: begin
                last_raw_next = raw;
                if (raw != stable_reg && deb_hit) begin
                    stable_next = raw;
                    if (raw && count_reg != CountMax) begin
                        count_next = count_reg + 1'b1;
                    end
                end

                if (cfg_reg.multi_click) begin
                    if (!stable_next && gap_hit) begin
                        published_next = {1'b0, count_next};
                        count_next     = '0;
                    end else if (stable_next && long_hit) begin
                        // long press publishes the count negated
                        published_next = -{1'b0, count_next};
                        count_next     = '0;
                    end
                end else if (count_next != '0) begin
                    published_next = {1'b0, count_next};
                    count_next     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            stamp_reg     <= '0;
            count_reg     <= '0;
            published_reg <= '0;
        end else if (advance) begin
            last_raw_reg  <= last_raw_next;
            stable_reg    <= stable_next;
            stamp_reg     <= stamp_next;
            count_reg     <= count_next;
            published_reg <= published_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_pressed_reg <= stable_next;
            out_clicks_reg  <= fetched;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(MTdataW-ClicksW-1){1'b0}}, out_clicks_reg, out_pressed_reg};

endmodule

### src/bdcc_checker.sv
// bdcc_checker: port-level assertions for the button debounce click counter
// depends on bdcc_pkg; bound to button_debounce_click_counter_unit below

module bdcc_checker
    import bdcc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [MTdataW-1:0] m_axis_tdata
);

    // no result is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // click value never reaches -128, the count saturates at 127
    a_clicks_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[ClicksW:1] != 8'h80)
        else $error("click value out of range");

    // an accepted input is followed by a valid result on m_axis
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted item produced no result");

endmodule

bind button_debounce_click_counter_unit bdcc_checker u_bdcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/bdcc_click_checker.sv
// bdcc_click_checker: watches the item, result and register channels of the
// button debounce click counter, predicts each result and compares it
// depends on bdcc_pkg

module bdcc_click_checker
    import bdcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [STdataW-1:0]   s_axis_tdata,   // [0] pin_level, [32:1] now_ms, zero pad
    input  logic                 s_axis_tuser,   // [0] command

    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [MTdataW-1:0]   m_axis_tdata,   // [0] pressed, [8:1] clicks, zero pad

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,

    output int unsigned          fail_count,
    output int unsigned          pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      pressed;
        logic [ClicksW-1:0]        clicks;
    } report_t;

    // shadow of the block's registers and button state
    cfg_t               settings;
    logic               last_raw;
    logic               debounced;
    logic [TimeW-1:0]   bounce_stamp;
    logic [CountW-1:0]  click_count;
    logic [ClicksW-1:0] published;

    report_t     awaited_reports[$];
    int unsigned mismatches = 0;

    // one item through the debounce and click logic, returns its report
    function automatic report_t debounce_and_count(cmd_t cmd, logic pin,
                                                   logic [TimeW-1:0] now);
        report_t          rep;
        logic             raw;
        logic [TimeW-1:0] elapsed;
        rep.clicks = '0;
        if (cmd == CMD_FETCH) begin
            rep.clicks = published;
            published  = '0;
        end else begin
            raw = ~pin;
            if (raw != last_raw) bounce_stamp = now;
            elapsed = now - bounce_stamp;
            if (raw != debounced && elapsed > settings.debounce_ms) begin
                debounced = raw;
                if (debounced && click_count != CountMax) click_count = click_count + 1'b1;
            end
            if (settings.multi_click) begin
                if (!debounced && elapsed > settings.gap_ms) begin
                    published   = {1'b0, click_count};
                    click_count = '0;
                end
                if (debounced && elapsed > settings.long_ms) begin
                    published   = -{1'b0, click_count};
                    click_count = '0;
                end
            end else if (click_count != '0) begin
                published   = {1'b0, click_count};
                click_count = '0;
            end
            last_raw = raw;
        end
        rep.pressed = debounced;
        return rep;
    endfunction

    always @(posedge aclk) begin : watch
        report_t got;
        report_t want;
        if (!aresetn) begin
            settings.multi_click = 1'b0;
            settings.debounce_ms = DebounceMsRst;
            settings.gap_ms      = GapMsRst;
            settings.long_ms     = LongMsRst;
            last_raw     = 1'b0;
            debounced    = 1'b0;
            bounce_stamp = '0;
            click_count  = '0;
            published    = '0;
            awaited_reports.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.pressed = m_axis_tdata[0];
                got.clicks  = m_axis_tdata[ClicksW:1];
                if (awaited_reports.size() == 0) begin
                    $display("%0t: result with none awaited, actual pressed %0d clicks %0d",
                             $time, got.pressed, $signed(got.clicks));
                    mismatches++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (got.pressed !== want.pressed) begin
                        $display("%0t: pressed mismatch, expected %0d, actual %0d",
                                 $time, want.pressed, got.pressed);
                        mismatches++;
                    end
                    if (got.clicks !== want.clicks) begin
                        $display("%0t: clicks mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.clicks), $signed(got.clicks));
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    RegMultiClick: settings.multi_click = cfg_data[0];
                    RegDebounceMs: settings.debounce_ms = cfg_data[MsW-1:0];
                    RegGapMs:      settings.gap_ms      = cfg_data[MsW-1:0];
                    RegLongMs:     settings.long_ms     = cfg_data[MsW-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                awaited_reports.push_back(debounce_and_count(cmd_t'(s_axis_tuser),
                                                             s_axis_tdata[0],
                                                             s_axis_tdata[TimeW:1]));
            end
        end
        pending    <= awaited_reports.size();
        fail_count <= mismatches;
    end

endmodule

### tb/tb_button_debounce_click_counter_unit.sv
// tb_button_debounce_click_counter_unit: stimulus and verdict for the button
// debounce click counter; directed cases, click saturation, random phases
// depends on bdcc_pkg, button_debounce_click_counter_unit and bdcc_click_checker

module tb_button_debounce_click_counter_unit;

    import bdcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // generous: well above the slowest legal run
    localparam int unsigned CycleLimit  = 1000000;
    localparam int unsigned PhaseItems  = 16;
    localparam int unsigned RandPhases  = 10;
    localparam int unsigned SatClicks   = 128;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [STdataW-1:0]  s_axis_tdata = '0;   // [0] pin_level, [32:1] now_ms, zero pad
    logic                s_axis_tuser = 1'b0; // [0] command

    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [MTdataW-1:0]  m_axis_tdata;        // [0] pressed, [8:1] clicks, zero pad

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int unsigned         fail_count;
    int unsigned         pending;

    // stimulus-side knowledge of the current timing, only used to aim steps
    logic [MsW-1:0]      cur_db = DebounceMsRst;
    logic [MsW-1:0]      cur_gap = GapMsRst;
    logic [MsW-1:0]      cur_long = LongMsRst;
    logic [TimeW-1:0]    ms_clock = '0;
    logic                cur_pin = 1'b1;
    logic                steady = 1'b0;   // phase without any idling on either side
    int unsigned         items_sent = 0;
    int unsigned         cycle_count = 0;
    int unsigned         ready_run = 0;

    always #2 aclk = ~aclk;

    button_debounce_click_counter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    bdcc_click_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 9);
        return $urandom_range(20, 60);
    endfunction

    // time step aimed around the thresholds, with some small and large jumps
    function automatic logic [TimeW-1:0] pick_step();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25) return cur_db + $urandom_range(0, 1);
        if (r < 40) return cur_gap + $urandom_range(0, 1);
        if (r < 55) return cur_long + $urandom_range(0, 1);
        if (r < 85) return $urandom_range(0, 40);
        return $urandom_range(0, 140000);
    endfunction

    // result side: random back-pressure, held ready in steady phases
    always @(posedge aclk) begin
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
            ready_run     <= 8;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            ready_run     <= idle_len();
        end else begin
            m_axis_tready <= 1'b1;
            ready_run     <= $urandom_range(0, 12);
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("button_debounce_click_counter_unit regression: fail");
            $finish;
        end
    end

    // one transaction on the item channel, then an optional gap
    task automatic send_item(input cmd_t cmd, input logic pin, input logic [TimeW-1:0] now);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(STdataW-TimeW-1){1'b0}}, now, pin};
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // pin sample at the running clock advanced by dt
    task automatic step_sample(input logic pin, input logic [TimeW-1:0] dt);
        ms_clock = ms_clock + dt;
        send_item(CMD_SAMPLE, pin, ms_clock);
    endtask

    // drain: every result back, then let the two pipeline stages settle
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // full register set, written only once the block is idle
    task automatic set_config(input logic multi, input logic [MsW-1:0] db,
                              input logic [MsW-1:0] gap, input logic [MsW-1:0] lng);
        wait_quiet();
        // upper data bits of the mode register are junk and must be masked
        cfg_write(RegMultiClick, {(CfgDataW-1)'($urandom_range(0, 32767)), multi});
        cfg_write(RegDebounceMs, db);
        cfg_write(RegGapMs, gap);
        cfg_write(RegLongMs, lng);
        // an index past the register list is dropped
        cfg_write(CfgIdxW'($urandom_range(4, 255)), CfgDataW'($urandom()));
        cur_db   = db;
        cur_gap  = gap;
        cur_long = lng;
    endtask

    initial begin : stimulus
        int unsigned r;
        int unsigned n;
        int unsigned phase_end;
        logic        m;
        logic [MsW-1:0] db;
        logic [MsW-1:0] gap;
        logic [MsW-1:0] lng;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single mode at reset settings
        // fetch right after reset, ignored fields at all ones
        send_item(CMD_FETCH, 1'b0, '1);
        send_item(CMD_SAMPLE, 1'b1, '0);
        // press: exactly at the debounce time is not enough, one past is
        send_item(CMD_SAMPLE, 1'b0, 100);
        send_item(CMD_SAMPLE, 1'b0, 120);
        send_item(CMD_SAMPLE, 1'b0, 121);
        // fetch returns the click, second fetch finds it cleared
        send_item(CMD_FETCH, 1'b1, '0);
        send_item(CMD_FETCH, 1'b0, 32'h5555_5555);
        send_item(CMD_SAMPLE, 1'b1, 130);
        send_item(CMD_SAMPLE, 1'b1, 151);
        // elapsed time across the 32-bit wrap
        send_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFF0);
        send_item(CMD_SAMPLE, 1'b0, 32'h0000_0010);
        // timestamp going backward looks like a very long wait
        send_item(CMD_SAMPLE, 1'b1, 1000);
        send_item(CMD_SAMPLE, 1'b1, 500);
        send_item(CMD_FETCH, 1'b1, 32'hAAAA_AAAA);

        // unknown indexes at both ends of the index range
        wait_quiet();
        cfg_write('1, '1);
        cfg_write(CfgIdxW'(4), '0);

        // multi-click mode: double click published after the gap
        set_config(1'b1, 16'd20, 16'd400, 16'd1000);
        send_item(CMD_SAMPLE, 1'b0, 10000);
        send_item(CMD_SAMPLE, 1'b0, 10030);
        send_item(CMD_SAMPLE, 1'b1, 10040);
        send_item(CMD_SAMPLE, 1'b1, 10070);
        send_item(CMD_SAMPLE, 1'b0, 10080);
        send_item(CMD_SAMPLE, 1'b0, 10110);
        send_item(CMD_SAMPLE, 1'b1, 10120);
        send_item(CMD_SAMPLE, 1'b1, 10150);
        send_item(CMD_SAMPLE, 1'b1, 10521);
        send_item(CMD_FETCH, 1'b0, '0);
        // a later qualifying release overwrites with the now empty count
        send_item(CMD_SAMPLE, 1'b1, 10600);
        // long press publishes the count negated
        send_item(CMD_SAMPLE, 1'b0, 11000);
        send_item(CMD_SAMPLE, 1'b0, 11030);
        send_item(CMD_SAMPLE, 1'b0, 12001);
        send_item(CMD_FETCH, 1'b1, '1);

        // count saturation: more than 127 clicks with nothing published
        set_config(1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
        ms_clock = 20000;
        step_sample(1'b1, 1);
        step_sample(1'b1, 1);
        for (n = 0; n < SatClicks; n++) begin
            step_sample(1'b0, 1);
            step_sample(1'b0, 1);
            step_sample(1'b1, 1);
            step_sample(1'b1, 1);
        end
        step_sample(1'b1, 70000);
        send_item(CMD_FETCH, 1'b0, '0);
        cur_pin = 1'b1;

        // random phases: first the reset settings and register extremes, then random settings
        for (int p = 0; p < RandPhases; p++) begin
            case (p)
                0: begin m = 1'b1; db = 16'd20; gap = 16'd400;  lng = 16'd1000; end
                1: begin m = 1'b1; db = 16'd0;  gap = 16'd0;    lng = 16'd0;    end
                2: begin m = 1'b1; db = 16'hFFFF; gap = 16'hFFFF; lng = 16'hFFFF; end
                3: begin m = 1'b0; db = 16'd0;  gap = 16'hFFFF; lng = 16'd0;    end
                default: begin
                    m   = ($urandom_range(0, 3) != 0);
                    db  = ($urandom_range(0, 9) == 0) ? MsW'($urandom_range(0, 65535))
                                                      : MsW'($urandom_range(0, 40));
                    gap = ($urandom_range(0, 9) == 0) ? MsW'($urandom_range(0, 65535))
                                                      : MsW'($urandom_range(0, 600));
                    lng = ($urandom_range(0, 9) == 0) ? MsW'($urandom_range(0, 65535))
                                                      : MsW'($urandom_range(0, 1500));
                end
            endcase
            set_config(m, db, gap, lng);
            steady <= (p % 4 == 3);
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_item(CMD_FETCH, 1'($urandom_range(0, 1)), $urandom());
                end else if (r < 18) begin
                    // stray sample anywhere in time, the running clock stays put
                    send_item(CMD_SAMPLE, 1'($urandom_range(0, 1)), $urandom());
                end else begin
                    // mostly one button transition: bounce, settle, then hold
                    n = $urandom_range(0, 3);
                    for (int b = 0; b < n; b++) step_sample(cur_pin ^ !b[0], $urandom_range(0, 5));
                    cur_pin = ($urandom_range(0, 4) != 0) ? ~cur_pin : cur_pin;
                    step_sample(cur_pin, $urandom_range(0, 5));
                    n = $urandom_range(1, 3);
                    for (int h = 0; h < n; h++) step_sample(cur_pin, pick_step());
                end
            end
        end

        steady <= 1'b0;
        wait_quiet();
        if (fail_count == 0) begin
            $display("button_debounce_click_counter_unit regression: pass");
        end else begin
            $display("button_debounce_click_counter_unit regression: fail");
        end
        $finish;
    end

endmodule
